/* hdl/zero_compress_16bit_blocks_defines.svh */
// Assertion macros used by the compressor design file.
`ifndef ZERO_COMPRESS_16BIT_BLOCKS_DEFINES_SVH
`define ZERO_COMPRESS_16BIT_BLOCKS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZC16_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZC16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/zc16_pkg.sv */
package zc16_pkg;

  localparam int BLOCK_ELEMENTS = 64;
  localparam int COUNT_BITS     = 32;
  localparam int CHUNK_WORDS    = 4;
  localparam int WORD_W         = 16;
  localparam int BYTES_W        = 32;
  localparam int CNT_W          = 3;
  localparam int POS_W          = $clog2(BLOCK_ELEMENTS);
  localparam int NZC_W          = POS_W + 1;
  localparam int LANE_W         = $clog2(CHUNK_WORDS);
  localparam int BANK_DEPTH     = BLOCK_ELEMENTS / CHUNK_WORDS;
  localparam int ROW_W          = $clog2(BANK_DEPTH);
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 136;

  typedef enum logic [1:0] {
    ZC_FILL,
    ZC_RD,
    ZC_DATA
  } zc16_state_t;

endpackage

/* hdl/zc16_ram.sv */
module zc16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/zero_compress_16bit_blocks.sv */
// Zero-value compressor for a stream of 16-bit words in blocks of 64. Within a block one
// item is accepted every cycle while the output register is free or being taken. When a
// block closes (its 64th item, or an item with tlast) the block's tag goes out at once as
// a four-word chunk, and input is held off while the nonzero words drain in chunks of up
// to four: each data chunk needs the registered read of the four-bank word store and then
// a load of the output register, and any output stall holds the drain.
// An output chunk with stream_done set carries the stream's byte totals; after it the
// block starts a fresh stream.
`include "zero_compress_16bit_blocks_defines.svh"

module zero_compress_16bit_blocks (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] value
  input  logic [zc16_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] word_0, [31:16] word_1, [47:32] word_2, [63:48] word_3, [66:64] word_count,
  // [67] stream_done, [99:68] bytes_in, [131:100] bytes_out, [135:132] zero
  output logic [zc16_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  // [0] is_tag
  output logic                               out_tuser
);

  localparam int BE  = zc16_pkg::BLOCK_ELEMENTS;
  localparam int CW  = zc16_pkg::CHUNK_WORDS;
  localparam int WW  = zc16_pkg::WORD_W;
  localparam int PW  = zc16_pkg::POS_W;
  localparam int NW  = zc16_pkg::NZC_W;
  localparam int RW  = zc16_pkg::ROW_W;
  localparam int LW  = zc16_pkg::LANE_W;
  localparam int CB  = zc16_pkg::COUNT_BITS;
  localparam int BW  = zc16_pkg::BYTES_W;
  localparam int KW  = zc16_pkg::CNT_W;

  zc16_pkg::zc16_state_t state_r, state_nxt;

  logic [PW-1:0]  pos_r, pos_nxt;
  logic [NW-1:0]  nzc_r, nzc_nxt;
  logic [BE-1:0]  tag_r, tag_nxt;
  logic [CB-1:0]  win_r, win_nxt;
  logic [CB-1:0]  wout_r, wout_nxt;
  logic [NW-1:0]  blk_nzc_r, blk_nzc_nxt;
  logic           blk_last_r, blk_last_nxt;
  logic [CB-1:0]  fin_in_r, fin_in_nxt;
  logic [CB-1:0]  fin_out_r, fin_out_nxt;
  logic [RW-1:0]  chunk_r, chunk_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [WW-1:0]  out_word_r [CW];
  logic [WW-1:0]  out_word_nxt [CW];
  logic [KW-1:0]  out_cnt_r, out_cnt_nxt;
  logic           out_tag_r, out_tag_nxt;
  logic           out_lor_r, out_lor_nxt;
  logic           out_done_r, out_done_nxt;
  logic [BW-1:0]  out_bin_r, out_bin_nxt;
  logic [BW-1:0]  out_bout_r, out_bout_nxt;

  logic [WW-1:0]  rd_data [CW];

  logic           in_acc;
  logic           out_free;
  logic           load_data;
  logic           closing;
  logic           is_zero;
  logic [WW-1:0]  in_value;
  logic [BE-1:0]  tag_upd;
  logic [NW-1:0]  nzc_upd;
  logic [CB-1:0]  win_upd;
  logic [CB-1:0]  wout_upd;
  logic [NW-1:0]  rem;
  logic           last_chunk;
  logic [KW-1:0]  chunk_n;
  logic           tag_done;
  logic           data_done;

  assign in_value = in_tdata[WW-1:0];
  assign is_zero  = (in_value == '0);
  assign in_acc   = in_tvalid && in_tready;
  assign closing  = in_acc && (in_tlast || (pos_r == PW'(BE - 1)));

  assign tag_upd  = is_zero ? (tag_r & ~({{(BE-1){1'b0}}, 1'b1} << pos_r)) : tag_r;
  assign nzc_upd  = is_zero ? nzc_r : (nzc_r + NW'(1));
  assign win_upd  = win_r + CB'(1);
  assign wout_upd = wout_r + CB'(CW) + CB'(nzc_upd);

  // Words still left to send from the current data chunk onward.
  assign rem        = blk_nzc_r - NW'({chunk_r, {LW{1'b0}}});
  assign last_chunk = (rem <= NW'(CW));
  assign chunk_n    = (rem >= NW'(CW)) ? KW'(CW) : rem[KW-1:0];
  assign tag_done   = in_tlast && (nzc_upd == '0);
  assign data_done  = blk_last_r && last_chunk;

  // The nonzero words are banked by the low bits of their index, so one read at
  // the chunk's row returns all four words of that chunk.
  for (genvar b = 0; b < CW; b++) begin : g_bank
    logic bank_we;
    assign bank_we = in_acc && !is_zero && (nzc_r[LW-1:0] == LW'(b));
    zc16_ram #(
      .WIDTH(WW),
      .DEPTH(zc16_pkg::BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we),
      .waddr(nzc_r[LW +: RW]),
      .wdata(in_value),
      .raddr(chunk_r),
      .rdata(rd_data[b])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zc16_pkg::ZC_FILL: begin
        if (closing && (nzc_upd != '0)) begin
          state_nxt = zc16_pkg::ZC_RD;
        end
      end
      zc16_pkg::ZC_RD: begin
        state_nxt = zc16_pkg::ZC_DATA;
      end
      zc16_pkg::ZC_DATA: begin
        if (load_data) begin
          state_nxt = last_chunk ? zc16_pkg::ZC_FILL : zc16_pkg::ZC_RD;
        end
      end
      default: begin
        state_nxt = zc16_pkg::ZC_FILL;
      end
    endcase
  end

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    in_tready = 1'b0;
    load_data = 1'b0;
    case (state_r)
      zc16_pkg::ZC_FILL: begin
        in_tready = out_free;
      end
      zc16_pkg::ZC_DATA: begin
        load_data = out_free;
      end
      default: begin
        in_tready = 1'b0;
        load_data = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    nzc_nxt       = nzc_r;
    tag_nxt       = tag_r;
    win_nxt       = win_r;
    wout_nxt      = wout_r;
    blk_nzc_nxt   = blk_nzc_r;
    blk_last_nxt  = blk_last_r;
    fin_in_nxt    = fin_in_r;
    fin_out_nxt   = fin_out_r;
    chunk_nxt     = chunk_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_cnt_nxt   = out_cnt_r;
    out_tag_nxt   = out_tag_r;
    out_lor_nxt   = out_lor_r;
    out_done_nxt  = out_done_r;
    out_bin_nxt   = out_bin_r;
    out_bout_nxt  = out_bout_r;

    if (closing) begin
      pos_nxt      = '0;
      nzc_nxt      = '0;
      tag_nxt      = '1;
      blk_nzc_nxt  = nzc_upd;
      blk_last_nxt = in_tlast;
      fin_in_nxt   = win_upd;
      fin_out_nxt  = wout_upd;
      win_nxt      = in_tlast ? '0 : win_upd;
      wout_nxt     = in_tlast ? '0 : wout_upd;
      chunk_nxt    = '0;

      out_valid_nxt = 1'b1;
      for (int k = 0; k < CW; k++) begin
        out_word_nxt[k] = tag_upd[k*WW +: WW];
      end
      out_cnt_nxt  = KW'(CW);
      out_tag_nxt  = 1'b1;
      out_lor_nxt  = (nzc_upd == '0);
      out_done_nxt = tag_done;
      out_bin_nxt  = tag_done ? BW'({win_upd, 1'b0}) : '0;
      out_bout_nxt = tag_done ? BW'({wout_upd, 1'b0}) : '0;
    end else if (in_acc) begin
      pos_nxt = pos_r + PW'(1);
      nzc_nxt = nzc_upd;
      tag_nxt = tag_upd;
      win_nxt = win_upd;
    end

    if (load_data) begin
      if (!last_chunk) begin
        chunk_nxt = chunk_r + RW'(1);
      end
      out_valid_nxt = 1'b1;
      for (int k = 0; k < CW; k++) begin
        out_word_nxt[k] = (KW'(k) < chunk_n) ? rd_data[k] : '0;
      end
      out_cnt_nxt  = chunk_n;
      out_tag_nxt  = 1'b0;
      out_lor_nxt  = last_chunk;
      out_done_nxt = data_done;
      out_bin_nxt  = data_done ? BW'({fin_in_r, 1'b0}) : '0;
      out_bout_nxt = data_done ? BW'({fin_out_r, 1'b0}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zc16_pkg::ZC_FILL;
      pos_r       <= '0;
      nzc_r       <= '0;
      tag_r       <= '1;
      win_r       <= '0;
      wout_r      <= '0;
      chunk_r     <= '0;
      blk_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      nzc_r       <= nzc_nxt;
      tag_r       <= tag_nxt;
      win_r       <= win_nxt;
      wout_r      <= wout_nxt;
      chunk_r     <= chunk_nxt;
      blk_last_r  <= blk_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_nzc_r  <= blk_nzc_nxt;
    fin_in_r   <= fin_in_nxt;
    fin_out_r  <= fin_out_nxt;
    out_word_r <= out_word_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_tag_r  <= out_tag_nxt;
    out_lor_r  <= out_lor_nxt;
    out_done_r <= out_done_nxt;
    out_bin_r  <= out_bin_nxt;
    out_bout_r <= out_bout_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_lor_r;
  assign out_tuser  = out_tag_r;
  assign out_tdata  = {4'b0000, out_bout_r, out_bin_r, out_done_r, out_cnt_r,
                       out_word_r[3], out_word_r[2], out_word_r[1], out_word_r[0]};

  `ZC16_ASSERT_NOW(a_tag_full, out_valid_r && out_tag_r, out_cnt_r == KW'(CW), "tag chunk must hold four words")
  `ZC16_ASSERT_NOW(a_done_last, out_valid_r && out_done_r, out_lor_r, "stream end must close a block")
  `ZC16_ASSERT_NEXT(a_close_tag, closing, out_valid_r && out_tag_r, "block close must present its tag")
  `ZC16_ASSERT_NOW(a_nzc_bound, state_r == zc16_pkg::ZC_FILL, nzc_r <= NW'(pos_r), "nonzero count exceeds block position")

endmodule

/* tb/tb_zero_compress_16bit_blocks.sv */
`timescale 1ns / 100ps

module tb_zero_compress_16bit_blocks;

  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_TAIL    = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int BLK          = zc16_pkg::BLOCK_ELEMENTS;

  typedef struct packed {
    logic [3:0][15:0] words;
    logic [2:0]       count;
    logic             is_tag;
    logic             last_of_run;
    logic             stream_done;
    logic [31:0]      bytes_in;
    logic [31:0]      bytes_out;
  } zc_chunk_t;

  typedef struct packed {
    logic [15:0] value;
    logic        fin;
    logic        typed;
    zc_chunk_t   want;
  } elem_t;

  localparam zc_chunk_t NO_CHUNK = '0;

  // Short streams: extremes of the value, single-element streams, a step inside a
  // block, a short all-zero block and a block whose data spills over one chunk.
  localparam elem_t DIRECTED [21] = '{
    '{16'h0000, 1'b1, 1'b1, '{words: {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE},
      count: 3'd4, is_tag: 1'b1, last_of_run: 1'b1, stream_done: 1'b1,
      bytes_in: 32'd2, bytes_out: 32'd8}},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b1, 1'b1, '{words: {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFC},
      count: 3'd4, is_tag: 1'b1, last_of_run: 1'b1, stream_done: 1'b1,
      bytes_in: 32'd4, bytes_out: 32'd8}},
    '{16'hFFFF, 1'b1, 1'b0, NO_CHUNK},
    '{16'h0001, 1'b0, 1'b0, NO_CHUNK},
    '{16'h8000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h1234, 1'b0, 1'b0, NO_CHUNK},
    '{16'hABCD, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h5555, 1'b0, 1'b0, NO_CHUNK},
    '{16'hAAAA, 1'b1, 1'b0, NO_CHUNK},
    '{16'h7FFF, 1'b0, 1'b0, NO_CHUNK},
    '{16'hFFFE, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0001, 1'b1, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b0, 1'b0, NO_CHUNK},
    '{16'hFFFF, 1'b0, 1'b0, NO_CHUNK},
    '{16'h0000, 1'b1, 1'b0, NO_CHUNK}
  };

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [zc16_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [zc16_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             out_tuser;

  // Predictor state.
  logic [15:0] nz_store [BLK];
  logic [63:0] tag_mask  = '1;
  logic [5:0]  blk_pos   = '0;
  logic [6:0]  nz_cnt    = '0;
  logic [31:0] in_words  = '0;
  logic [31:0] out_words = '0;

  zc_chunk_t chunks_due [$];
  elem_t     stim [$];
  int        mismatches = 0;
  int        cycle_cnt  = 0;
  bit        calm       = 1'b0;

  zero_compress_16bit_blocks u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic zc_chunk_t make_chunk(logic [3:0][15:0] words, int n, logic tag,
                                           logic run_end, logic done);
    zc_chunk_t c;
    c.words       = words;
    c.count       = 3'(n);
    c.is_tag      = tag;
    c.last_of_run = run_end;
    c.stream_done = done;
    c.bytes_in    = done ? (in_words << 1) : 32'd0;
    c.bytes_out   = done ? (out_words << 1) : 32'd0;
    return c;
  endfunction

  // Folds one element into the current block and appends the chunks it releases.
  function automatic void pack_element(logic [15:0] value, logic fin, ref zc_chunk_t dst [$]);
    int               nchunks;
    int               n;
    logic [3:0][15:0] words;
    if (value == 16'h0000) begin
      tag_mask[blk_pos] = 1'b0;
    end else begin
      nz_store[nz_cnt[5:0]] = value;
      nz_cnt = nz_cnt + 7'd1;
    end
    in_words = in_words + 32'd1;
    if (blk_pos != 6'(BLK - 1) && !fin) begin
      blk_pos = blk_pos + 6'd1;
      return;
    end
    out_words = out_words + 32'd4 + 32'(nz_cnt);
    nchunks = (int'(nz_cnt) + 3) / 4;
    dst.push_back(make_chunk(tag_mask, 4, 1'b1, nchunks == 0, fin && nchunks == 0));
    for (int c = 0; c < nchunks; c++) begin
      n = int'(nz_cnt) - 4 * c;
      if (n > 4) n = 4;
      for (int k = 0; k < 4; k++) begin
        words[k] = (k < n) ? nz_store[4 * c + k] : 16'h0000;
      end
      dst.push_back(make_chunk(words, n, 1'b0, c == nchunks - 1, fin && c == nchunks - 1));
    end
    tag_mask = '1;
    blk_pos  = '0;
    nz_cnt   = '0;
    if (fin) begin
      in_words  = '0;
      out_words = '0;
    end
  endfunction

  function automatic logic [15:0] random_value(int zero_pct);
    if ($urandom_range(1, 100) <= zero_pct) return 16'h0000;
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0001;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Whole streams with random length and zero density; the first two force a full
  // all-zero block and a full block with no zeros. The last stream is cut short so
  // the item count stays on target.
  function automatic void build_stimulus();
    int    len;
    int    zero_pct;
    int    streams;
    int    room;
    elem_t e;
    foreach (DIRECTED[i]) stim.push_back(DIRECTED[i]);
    streams = 0;
    while (stim.size() < $size(DIRECTED) + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: len = $urandom_range(1, 4);
        2: len = BLK - 1;
        3: len = BLK;
        4: len = BLK + 1;
        5: len = 2 * BLK;
        default: len = $urandom_range(5, 40);
      endcase
      case ($urandom_range(0, 3))
        0: zero_pct = 100;
        1: zero_pct = 0;
        2: zero_pct = 50;
        default: zero_pct = 85;
      endcase
      if (streams == 0) begin
        len = BLK + 1;
        zero_pct = 100;
      end else if (streams == 1) begin
        len = BLK;
        zero_pct = 0;
      end
      room = $size(DIRECTED) + RANDOM_ITEMS - stim.size();
      if (len > room) len = room;
      for (int i = 0; i < len; i++) begin
        e = '0;
        e.value = random_value(zero_pct);
        e.fin = (i == len - 1);
        stim.push_back(e);
      end
      streams++;
    end
  endfunction

  // Output side: ready drops in bursts, with quiet stretches and none at the tail.
  initial begin : ready_gen
    int stall_pct;
    stall_pct = 25;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      if (!calm && $urandom_range(1, 100) <= stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : chunk_check
    zc_chunk_t got;
    zc_chunk_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.words       = out_tdata[63:0];
      got.count       = out_tdata[66:64];
      got.stream_done = out_tdata[67];
      got.bytes_in    = out_tdata[99:68];
      got.bytes_out   = out_tdata[131:100];
      got.last_of_run = out_tlast;
      got.is_tag      = out_tuser;
      if (chunks_due.size() == 0) begin
        $error("unexpected chunk: words %h count %0d", got.words, got.count);
        mismatches++;
      end else begin
        want = chunks_due.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got.words[k] !== want.words[k]) begin
            $error("word_%0d: expected %h, got %h", k, want.words[k], got.words[k]);
            mismatches++;
          end
        end
        if (got.count !== want.count) begin
          $error("word_count: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
        if (got.is_tag !== want.is_tag) begin
          $error("is_tag: expected %b, got %b", want.is_tag, got.is_tag);
          mismatches++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
          mismatches++;
        end
        if (got.stream_done !== want.stream_done) begin
          $error("stream_done: expected %b, got %b", want.stream_done, got.stream_done);
          mismatches++;
        end
        if (got.bytes_in !== want.bytes_in) begin
          $error("bytes_in: expected %0d, got %0d", want.bytes_in, got.bytes_in);
          mismatches++;
        end
        if (got.bytes_out !== want.bytes_out) begin
          $error("bytes_out: expected %0d, got %0d", want.bytes_out, got.bytes_out);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : feed
    int        gap_pct;
    zc_chunk_t fresh [$];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    gap_pct    = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int idx = 0; idx < stim.size(); idx++) begin
      if (idx % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      calm = (idx >= stim.size() - CALM_TAIL);
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stim[idx].value;
      in_tlast  <= stim[idx].fin;
      do @(posedge clk); while (!in_tready);
      fresh.delete();
      pack_element(stim[idx].value, stim[idx].fin, fresh);
      // Rows with a hand-written expectation release exactly one chunk.
      if (stim[idx].typed) begin
        chunks_due.push_back(stim[idx].want);
      end else begin
        foreach (fresh[i]) chunks_due.push_back(fresh[i]);
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/zc16_pkg.sv
hdl/zc16_ram.sv
hdl/zero_compress_16bit_blocks.sv
tb/tb_zero_compress_16bit_blocks.sv
